// File: hdl/deh_pkg.sv
package deh_pkg;

  localparam int unsigned ESUM_W = 48;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned BIN_W  = ESUM_W + SQ_W + CNT_W;
  localparam int unsigned CFG_W  = 31;
  localparam int unsigned QUO_W  = 33;

  typedef enum logic [1:0] {
    MODE_HIT   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_MERGE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  localparam logic CFG_MAX_DEPTH = 1'b0;
  localparam logic CFG_BIN_WIDTH = 1'b1;

  typedef struct packed {
    logic [ESUM_W-1:0] esum;
    logic [SQ_W-1:0]   sq;
    logic [CNT_W-1:0]  cnt;
  } bin_t;

  function automatic bin_t bin_add(bin_t a, bin_t b);
    bin_t r;
    logic [ESUM_W:0] e;
    logic [SQ_W:0]   s;
    logic [CNT_W:0]  c;
    e = {1'b0, a.esum} + {1'b0, b.esum};
    s = {1'b0, a.sq} + {1'b0, b.sq};
    c = {1'b0, a.cnt} + {1'b0, b.cnt};
    r.esum = e[ESUM_W] ? {ESUM_W{1'b1}} : e[ESUM_W-1:0];
    r.sq   = s[SQ_W] ? {SQ_W{1'b1}} : s[SQ_W-1:0];
    r.cnt  = c[CNT_W] ? {CNT_W{1'b1}} : c[CNT_W-1:0];
    return r;
  endfunction

endpackage

// File: hdl/deh_ram.sv
module deh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/deh_div.sv
module deh_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [deh_pkg::QUO_W-1:0] dividend,
  input  logic [deh_pkg::QUO_W-1:0] divisor,
  output logic                      done,
  output logic [deh_pkg::QUO_W-1:0] quotient
);
  localparam int unsigned W = deh_pkg::QUO_W;

  logic [W-1:0]         q_r, q_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [W-1:0]         dv_r, dv_nxt;
  logic [$clog2(W)-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [W:0]           trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[W-1]} - {1'b0, dv_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dv_nxt   = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[W]) begin
        rem_nxt = {rem_r[W-2:0], q_r[W-1]};
        q_nxt   = {q_r[W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[W-1:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ($clog2(W))'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// File: hdl/depth_energy_histogram.sv
// Sequence: a hit runs the 33-step divider, waits for its done flag, then does a
//   read-modify-write, which it skips when the bin lies past the last; a rejected hit goes
//   straight to the result; clear and merge sweep one bin per cycle; a read passes a read and a wait state.
// Throughput: one transaction at a time; the divider and the bin sweep set the rate.
// Reset: synchronous, active low; after reset a clearing pass zeroes both bin memories
//   before the first transaction is taken.
module depth_energy_histogram #(
  parameter int unsigned BIN_COUNT = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   in_mode,
  input  logic [31:0]  in_energy,
  input  logic signed [31:0] in_local_z,
  input  logic [7:0]   in_read_bin,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         out_accepted,
  output logic [47:0]  out_run_energy_sum,
  output logic [63:0]  out_run_energy_square_sum,
  output logic [31:0]  out_run_hit_count,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);
  localparam int unsigned AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int unsigned BW = deh_pkg::BIN_W;
  localparam int unsigned QW = deh_pkg::QUO_W;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_HRD   = 9'b000001000,
    S_HWR   = 9'b000010000,
    S_SWEEP = 9'b000100000,
    S_RRD   = 9'b001000000,
    S_RWT   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [30:0] max_depth_r, bin_width_r;
  logic [1:0]  mode_r;
  logic [31:0] energy_r;
  logic [63:0] sq_r;
  logic [AW:0] idx_r, idx_nxt;
  logic [AW-1:0] bin_r;
  logic        sweep_clr_r;
  logic        acc_r;
  logic        rd_ok_r;
  deh_pkg::bin_t res_r;
  logic        pend_r;
  logic [AW-1:0] pw_addr_r;

  logic        ev_we, run_we;
  logic [AW-1:0] ev_waddr, ev_raddr, run_waddr, run_raddr;
  deh_pkg::bin_t ev_wdata, ev_rdata, run_wdata, run_rdata;

  logic        div_start, div_done;
  logic [QW-1:0] div_num, div_den, div_q;
  logic signed [33:0] d2;
  logic        hit_ok;
  logic        take;

  deh_ram #(.WIDTH(BW), .DEPTH(BIN_COUNT)) u_ev (
    .clk, .we(ev_we), .waddr(ev_waddr), .wdata(ev_wdata), .raddr(ev_raddr), .rdata(ev_rdata)
  );
  deh_ram #(.WIDTH(BW), .DEPTH(BIN_COUNT)) u_run (
    .clk, .we(run_we), .waddr(run_waddr), .wdata(run_wdata), .raddr(run_raddr),
    .rdata(run_rdata)
  );
  deh_div u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_num), .divisor(div_den),
    .done(div_done), .quotient(div_q)
  );

  assign d2 = 34'(signed'({in_local_z, 1'b0})) + 34'(signed'({3'b000, max_depth_r}));
  assign hit_ok = (in_energy != '0) && (bin_width_r != '0) && !d2[33] &&
                  (d2[32:0] < {1'b0, max_depth_r, 1'b0});
  assign take = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) || (state_r == S_INIT);
  assign div_start = take && (in_mode == deh_pkg::MODE_HIT) && hit_ok;
  assign div_num = d2[32:0];
  assign div_den = {1'b0, bin_width_r, 1'b0};

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ev_we     = 1'b0;
    ev_waddr  = bin_r;
    ev_wdata  = deh_pkg::bin_add(ev_rdata,
                  '{esum: 48'(energy_r), sq: sq_r, cnt: 32'd1});
    ev_raddr  = bin_r;
    run_we    = 1'b0;
    run_waddr = pw_addr_r;
    run_wdata = deh_pkg::bin_add(run_rdata, ev_rdata);
    run_raddr = idx_r[AW-1:0];
    case (state_r)
      S_INIT: begin
        ev_we = 1'b1; run_we = 1'b1;
        ev_waddr = idx_r[AW-1:0]; run_waddr = idx_r[AW-1:0];
        ev_wdata = '0; run_wdata = '0;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == (AW+1)'(BIN_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        idx_nxt = '0;
        if (take) begin
          case (in_mode)
            deh_pkg::MODE_HIT:   state_nxt = hit_ok ? S_DIV : S_OUT;
            deh_pkg::MODE_CLEAR: state_nxt = S_SWEEP;
            deh_pkg::MODE_MERGE: state_nxt = S_SWEEP;
            default:             state_nxt = S_RRD;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = (div_q < QW'(BIN_COUNT)) ? S_HRD : S_OUT;
      end
      S_HRD: state_nxt = S_HWR;
      S_HWR: begin
        ev_we = 1'b1;
        state_nxt = S_OUT;
      end
      S_SWEEP: begin
        ev_raddr = idx_r[AW-1:0];
        if (sweep_clr_r) begin
          ev_we = 1'b1; ev_waddr = idx_r[AW-1:0]; ev_wdata = '0;
        end else begin
          run_we = pend_r;
        end
        idx_nxt = idx_r + 1'b1;
        if (sweep_clr_r && idx_r == (AW+1)'(BIN_COUNT - 1)) state_nxt = S_OUT;
        if (!sweep_clr_r && idx_r == (AW+1)'(BIN_COUNT)) state_nxt = S_OUT;
      end
      S_RRD: begin
        run_raddr = bin_r;
        state_nxt = S_RWT;
      end
      S_RWT: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      idx_r       <= '0;
      max_depth_r <= 31'd1000000;
      bin_width_r <= 31'd3907;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= (state_r == S_SWEEP) && !sweep_clr_r && (idx_r < (AW+1)'(BIN_COUNT));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == deh_pkg::CFG_MAX_DEPTH) max_depth_r <= cfg_data;
        else                                     bin_width_r <= cfg_data;
      end
    end
    pw_addr_r <= idx_r[AW-1:0];
    if (take) begin
      mode_r      <= in_mode;
      energy_r    <= in_energy;
      sq_r        <= 64'(in_energy) * 64'(in_energy);
      sweep_clr_r <= (in_mode == deh_pkg::MODE_CLEAR);
      acc_r       <= (in_mode != deh_pkg::MODE_HIT);
      bin_r       <= in_read_bin[AW-1:0];
      rd_ok_r     <= (9'(in_read_bin) < 9'(BIN_COUNT));
      res_r       <= '0;
    end
    if (state_r == S_DIV && div_done) bin_r <= div_q[AW-1:0];
    if (state_r == S_HWR) acc_r <= 1'b1;
    if (state_r == S_RWT && rd_ok_r) res_r <= run_rdata;
  end

  assign out_valid                 = (state_r == S_OUT);
  assign out_accepted              = acc_r;
  assign out_run_energy_sum        = (mode_r == deh_pkg::MODE_READ) ? res_r.esum : '0;
  assign out_run_energy_square_sum = (mode_r == deh_pkg::MODE_READ) ? res_r.sq : '0;
  assign out_run_hit_count         = (mode_r == deh_pkg::MODE_READ) ? res_r.cnt : '0;
endmodule

// File: tb/sv/tb_depth_energy_histogram.sv
`timescale 1ns / 1ps

module tb_depth_energy_histogram;

  localparam int NBINS = 256;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    deh_pkg::mode_t mode;
    logic [31:0] energy;
    logic [31:0] z;
    logic [7:0]  rbin;
  } hist_item_t;

  typedef struct {
    logic        acc;
    logic [47:0] esum;
    logic [63:0] sqsum;
    logic [31:0] cnt;
  } hist_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [31:0] in_energy = '0;
  logic signed [31:0] in_local_z = '0;
  logic [7:0] in_read_bin = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  logic [47:0] out_run_energy_sum;
  logic [63:0] out_run_energy_square_sum;
  logic [31:0] out_run_hit_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;

  depth_energy_histogram DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // histogram mirror
  logic [30:0] mdl_max_depth = 31'd1000000;
  logic [30:0] mdl_bin_width = 31'd3907;
  logic [47:0] evt_esum [NBINS];
  logic [63:0] evt_sq   [NBINS];
  logic [31:0] evt_cnt  [NBINS];
  logic [47:0] run_esum [NBINS];
  logic [63:0] run_sq   [NBINS];
  logic [31:0] run_cnt  [NBINS];

  hist_item_t   pending_items[$];
  hist_result_t expected_results[$];
  hist_item_t   cur_item;

  bit quiet = 1'b0;
  bit hold_tx = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int mismatches = 0;
  int n_items = 0, n_results = 0, n_binned = 0, n_merges = 0, n_reads = 0;
  int n_phases = 0;
  longint cycles = 0;

  function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [63:0] sat64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic void clear_histogram();
    for (int i = 0; i < NBINS; i++) begin
      evt_esum[i] = '0; evt_sq[i] = '0; evt_cnt[i] = '0;
      run_esum[i] = '0; run_sq[i] = '0; run_cnt[i] = '0;
    end
  endfunction

  function automatic hist_result_t histogram_step(hist_item_t it);
    hist_result_t r;
    longint d2, lim;
    longint unsigned b;
    logic [63:0] sq;
    r = '{1'b1, '0, '0, '0};
    case (it.mode)
      deh_pkg::MODE_HIT: begin
        r.acc = 1'b0;
        d2 = 2 * longint'($signed(it.z)) + longint'(mdl_max_depth);
        lim = 2 * longint'(mdl_max_depth);
        if (it.energy != 0 && mdl_bin_width != 0 && d2 >= 0 && d2 < lim) begin
          b = longint'(d2) / (2 * longint'(mdl_bin_width));
          if (b < NBINS) begin
            sq = 64'(it.energy) * 64'(it.energy);
            evt_esum[b] = sat48(evt_esum[b], 48'(it.energy));
            evt_sq[b]   = sat64(evt_sq[b], sq);
            evt_cnt[b]  = sat32(evt_cnt[b], 32'd1);
            r.acc = 1'b1;
            n_binned++;
          end
        end
      end
      deh_pkg::MODE_CLEAR: begin
        for (int i = 0; i < NBINS; i++) begin
          evt_esum[i] = '0; evt_sq[i] = '0; evt_cnt[i] = '0;
        end
      end
      deh_pkg::MODE_MERGE: begin
        for (int i = 0; i < NBINS; i++) begin
          run_esum[i] = sat48(run_esum[i], evt_esum[i]);
          run_sq[i]   = sat64(run_sq[i], evt_sq[i]);
          run_cnt[i]  = sat32(run_cnt[i], evt_cnt[i]);
        end
        n_merges++;
      end
      default: begin
        r.esum  = run_esum[it.rbin];
        r.sqsum = run_sq[it.rbin];
        r.cnt   = run_cnt[it.rbin];
        n_reads++;
      end
    endcase
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(histogram_step(cur_item));
        n_items++;
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          in_gap = $urandom_range(1, 15);
          in_valid <= 1'b0;
        end else if (!hold_tx && pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_valid    <= 1'b1;
          in_mode     <= cur_item.mode;
          in_energy   <= cur_item.energy;
          in_local_z  <= cur_item.z;
          in_read_bin <= cur_item.rbin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    hist_result_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected transaction acc=%0b e=%0h s=%0h c=%0h",
                     out_accepted, out_run_energy_sum, out_run_energy_square_sum,
                     out_run_hit_count);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_accepted !== exp_r.acc || out_run_energy_sum !== exp_r.esum ||
              out_run_energy_square_sum !== exp_r.sqsum ||
              out_run_hit_count !== exp_r.cnt) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: result %0d exp acc=%0b e=%0h s=%0h c=%0h",
                        " got acc=%0b e=%0h s=%0h c=%0h"},
                       n_results, exp_r.acc, exp_r.esum, exp_r.sqsum, exp_r.cnt,
                       out_accepted, out_run_energy_sum, out_run_energy_square_sum,
                       out_run_hit_count);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("FAIL depth_energy_histogram");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [30:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == deh_pkg::CFG_MAX_DEPTH) mdl_max_depth = val;
    else mdl_bin_width = val;
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic hist_item_t mk(deh_pkg::mode_t m, logic [31:0] e, logic [31:0] z,
                                    logic [7:0] rb);
    hist_item_t it;
    it.mode = m; it.energy = e; it.z = z; it.rbin = rb;
    return it;
  endfunction

  // a hit mostly inside the configured depth range
  function automatic hist_item_t rand_hit(logic [30:0] md);
    hist_item_t it;
    longint d;
    int sel;
    sel = $urandom_range(0, 9);
    it = mk(deh_pkg::MODE_HIT, $urandom_range(1, 5000), $urandom, 8'($urandom));
    if (sel == 0) it.energy = '0;
    else if (sel == 1) it.energy = $urandom;
    else if (sel == 2) it.energy = '1;
    if (sel < 8 && md != 0) begin
      d = longint'({$urandom, $urandom} % (64'(md) << 1));
      it.z = 32'((d - longint'(md)) >>> 1);
    end
    return it;
  endfunction

  task automatic push_random(int count, logic [30:0] md, logic [30:0] bw);
    int n;
    hist_item_t h;
    longint unsigned b;
    logic [7:0] last_bin;
    n = 0;
    last_bin = '0;
    while (n < count) begin
      if ($urandom_range(0, 7) != 0) begin
        pending_items.push_back(mk(deh_pkg::MODE_CLEAR, $urandom, $urandom, 8'($urandom)));
        n++;
      end
      repeat ($urandom_range(2, 20)) begin
        h = rand_hit(md);
        if (bw != 0) begin
          b = longint'(2 * longint'($signed(h.z)) + longint'(md)) / (2 * longint'(bw));
          if (b < NBINS) last_bin = b[7:0];
        end
        pending_items.push_back(h);
        n++;
      end
      if ($urandom_range(0, 5) != 0) begin
        pending_items.push_back(mk(deh_pkg::MODE_MERGE, $urandom, $urandom, 8'($urandom)));
        n++;
      end
      repeat ($urandom_range(1, 4)) begin
        pending_items.push_back(mk(deh_pkg::MODE_READ, $urandom, $urandom,
                                   $urandom_range(0, 1) ? last_bin : 8'($urandom)));
        n++;
      end
    end
  endtask

  logic [30:0] md_list [10] = '{31'd1000000, 31'h7FFFFFFF, 31'd1, 31'h7FFFFFFF,
                                31'd1000, 31'd0, 31'd1000, 31'd65536,
                                31'h7FFFFFFF, 31'd1000000};
  logic [30:0] bw_list [10] = '{31'd3907, 31'h7FFFFFFF, 31'd1, 31'd1, 31'd4,
                                31'd5, 31'd0, 31'd256, 31'd8388608, 31'd3907};

  initial begin
    clear_histogram();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(deh_pkg::CFG_MAX_DEPTH, 31'd1000000);
    write_reg(deh_pkg::CFG_BIN_WIDTH, 31'd3907);
    // directed: boundaries, zero energy, square saturation, stray reads
    pending_items.push_back(mk(deh_pkg::MODE_CLEAR, '0, '0, '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, 32'd0, 32'd0, '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, '1, 32'(-500000), '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, '1, 32'(-500000), '1));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, '1, 32'(-500000), '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, 32'd7, 32'(-500001), '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, 32'd7, 32'd500000, '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, 32'd9, 32'd499999, '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, 32'd3, 32'h80000000, '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, 32'd3, 32'h7FFFFFFF, '0));
    pending_items.push_back(mk(deh_pkg::MODE_HIT, 32'd1, 32'd0, '0));
    pending_items.push_back(mk(deh_pkg::MODE_MERGE, '1, '1, '1));
    pending_items.push_back(mk(deh_pkg::MODE_READ, '0, '0, 8'd0));
    pending_items.push_back(mk(deh_pkg::MODE_READ, '0, '0, 8'd255));
    pending_items.push_back(mk(deh_pkg::MODE_READ, '1, '1, 8'd127));
    pending_items.push_back(mk(deh_pkg::MODE_MERGE, '0, '0, '0));
    pending_items.push_back(mk(deh_pkg::MODE_READ, '0, '0, 8'd0));
    pending_items.push_back(mk(deh_pkg::MODE_CLEAR, '1, '1, '1));
    pending_items.push_back(mk(deh_pkg::MODE_MERGE, '0, '0, '0));
    pending_items.push_back(mk(deh_pkg::MODE_READ, '0, '0, 8'd0));
    hold_tx = 1'b1;
    repeat ($urandom_range(20, 60)) @(posedge clk);
    hold_tx = 1'b0;

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      if (p == 9) quiet = 1'b1;
      write_reg(deh_pkg::CFG_MAX_DEPTH, md_list[p]);
      write_reg(deh_pkg::CFG_BIN_WIDTH, bw_list[p]);
      n_phases++;
      push_random(p == 9 ? 80 : 165, md_list[p], bw_list[p]);
    end

    wait_idle();
    repeat (300) @(posedge clk);
    $display("Covered %0d transactions over %0d register settings: %0d hits binned,",
             n_items, n_phases + 1, n_binned);
    $display("  %0d merges, %0d reads, %0d mismatches", n_merges, n_reads, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("PASS depth_energy_histogram");
    else
      $display("FAIL depth_energy_histogram");
    $finish;
  end

endmodule

// File: sim.f
hdl/deh_pkg.sv
hdl/deh_ram.sv
hdl/deh_div.sv
hdl/depth_energy_histogram.sv
tb/sv/tb_depth_energy_histogram.sv
